FILE: src/rss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rss_pkg;
  localparam int unsigned C_NEW = 3932;
  localparam int unsigned C_OLD = 61604;
  localparam logic [1:0] OP_OBSERVE  = 2'd0;
  localparam logic [1:0] OP_FORECAST = 2'd1;
  localparam logic [1:0] OP_LOAD     = 2'd2;
  localparam logic [2:0] REG_LEVEL_GAIN  = 3'd0;
  localparam logic [2:0] REG_SEASON_GAIN = 3'd1;
  localparam logic [2:0] REG_BAND_WIDTH  = 3'd2;
  localparam logic [2:0] REG_LEVEL_INIT  = 3'd3;
  localparam logic [2:0] REG_VAR_INIT    = 3'd4;

  // request to the shared divider
  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

FILE: src/robust_seasonal_smoother.sv
`timescale 1ns / 1ps
`default_nettype none
// Seasonal level smoother with outlier clipping. One transaction at a time:
// a load is written to the factor table on acceptance and the first observation
// echoes its value; a forecast result passes S_RD, S_MUL and S_PRED, and an
// observation result goes on through a square root, then two divisions on one
// shared divider; a zero divisor is answered without iterating.
// s_tready is low while busy. Results wait in an output register; the next
// transaction is taken while one waits only once it has been delivered.
// Factor slots wrap modulo SEASON_SLOTS.
module robust_seasonal_smoother #(
  parameter int SEASON_SLOTS = 8
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // [1:0] opcode, [4:2] day_index, [36:5] sample_value, zero fill
  input  wire  [39:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // [31:0] forecast_value
  output logic [31:0] m_tdata,
  // was_clipped
  output logic        m_tuser,
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import rss_pkg::*;
  localparam int AW = $clog2(SEASON_SLOTS > 1 ? SEASON_SLOTS : 2);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RD    = 11'b00000000010,
    S_MUL   = 11'b00000000100,
    S_PRED  = 11'b00000001000,
    S_VAR   = 11'b00000010000,
    S_SQ    = 11'b00000100000,
    S_BAND  = 11'b00001000000,
    S_CLIP  = 11'b00010000000,
    S_DIV1  = 11'b00100000000,
    S_DIV2  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state;
  logic [15:0] level_gain, season_gain, band_width;
  logic signed [31:0] level_init, level, last_sample, last_forecast, x, f, xh, fac;
  logic [31:0] variance_init;
  logic [47:0] error_variance;
  logic started, clipped, op_obs;
  logic [1:0] op;
  logic [AW-1:0] slot;
  logic signed [63:0] prod;
  logic [63:0] sq;
  logic [35:0] band;
  logic div_wait;

  logic ram_we;
  logic [31:0] ram_wdata, ram_rdata;
  div_req_t dreq;
  div_rsp_t drsp;
  logic sq_start, sq_done;
  logic [31:0] sd;

  rss_ram #(.WIDTH(32), .DEPTH(SEASON_SLOTS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(slot), .wdata(ram_wdata),
    .raddr(slot), .rdata(ram_rdata));
  rss_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
  rss_sqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start),
    .val({error_variance, 16'd0}), .done(sq_done), .root(sd));

  assign s_tready = (state == S_IDLE) && !m_tvalid;

  logic [2:0] in_day;
  assign in_day = s_tdata[4:2];

  // day index to slot: a small constant table, folded at elaboration
  function automatic logic [AW-1:0] slot_of(input logic [2:0] d);
    logic [AW-1:0] r;
    r = '0;
    for (int i = 0; i < 8; i++)
      if (d == 3'(i)) r = AW'(i % SEASON_SLOTS);
    return r;
  endfunction

  function automatic logic signed [31:0] blend(input logic [15:0] g,
      input logic signed [31:0] a, input logic signed [31:0] b);
    logic signed [65:0] s;
    s = $signed({1'b0, g}) * a + $signed({1'b0, 17'd65536 - {1'b0, g}}) * b + 66'sd32768;
    return sat32(s >>> 16);
  endfunction

  logic signed [32:0] e;
  logic [32:0] ue;
  logic [65:0] vsum;
  logic signed [37:0] lo, hi;
  always_comb begin
    e = $signed({last_sample[31], last_sample}) - $signed({last_forecast[31], last_forecast});
    ue = e[32] ? 33'(-e) : 33'(e);
    vsum = 66'(C_NEW) * 66'(sq[63:16]) + 66'(C_OLD) * 66'(error_variance) + 66'd32768;
    lo = $signed({{6{f[31]}}, f}) - $signed({2'b0, band});
    hi = $signed({{6{f[31]}}, f}) + $signed({2'b0, band});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      level_gain <= 16'd32768; season_gain <= 16'd32768; band_width <= 16'd8192;
      level_init <= '0; variance_init <= 32'd65536;
      level <= '0; error_variance <= '0; last_sample <= '0; last_forecast <= '0;
      started <= 1'b0;
      ram_we <= 1'b0; dreq.start <= 1'b0; sq_start <= 1'b0; div_wait <= 1'b0;
    end else begin
      ram_we <= 1'b0; dreq.start <= 1'b0; sq_start <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LEVEL_GAIN:  level_gain <= cfg_data[15:0];
          REG_SEASON_GAIN: season_gain <= cfg_data[15:0];
          REG_BAND_WIDTH:  band_width <= cfg_data[15:0];
          REG_LEVEL_INIT:  level_init <= cfg_data;
          REG_VAR_INIT:    variance_init <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          op <= s_tdata[1:0];
          slot <= slot_of(in_day);
          x <= s_tdata[36:5];
          unique case (s_tdata[1:0])
            OP_LOAD: begin
              ram_we <= 1'b1; ram_wdata <= s_tdata[36:5];
            end
            OP_FORECAST: state <= S_RD;
            OP_OBSERVE: begin
              if (!started) begin
                started <= 1'b1; level <= level_init;
                error_variance <= {16'd0, variance_init};
                last_sample <= s_tdata[36:5]; last_forecast <= s_tdata[36:5];
                m_tdata <= s_tdata[36:5]; m_tuser <= 1'b0; m_tvalid <= 1'b1;
              end else state <= S_RD;
            end
            default: ;
          endcase
        end
        S_RD: begin
          sq <= 64'(ue) * 64'(ue);
          state <= S_MUL;
        end
        S_MUL: begin
          fac <= ram_rdata;
          prod <= level * $signed(ram_rdata);
          state <= S_PRED;
        end
        S_PRED: begin
          f <= sat32(($signed({{2{prod[63]}}, prod}) + 66'sd32768) >>> 16);
          op_obs <= (op == OP_OBSERVE);
          if (op == OP_OBSERVE) state <= S_VAR;
          else begin
            m_tdata <= sat32(($signed({{2{prod[63]}}, prod}) + 66'sd32768) >>> 16);
            m_tuser <= 1'b0; m_tvalid <= 1'b1; state <= S_IDLE;
          end
        end
        S_VAR: begin
          error_variance <= (vsum[65:16] > 50'hFFFFFFFFFFFF) ? 48'hFFFFFFFFFFFF
                            : vsum[63:16];
          sq_start <= 1'b1;
          state <= S_SQ;
        end
        S_SQ: if (sq_done) begin
          band <= 36'((48'(band_width) * 48'(sd)) >> 12);
          state <= S_BAND;
        end
        S_BAND: begin
          if ($signed({{6{x[31]}}, x}) < lo) begin
            xh <= sat32(66'(lo)); clipped <= 1'b1;
          end else if ($signed({{6{x[31]}}, x}) > hi) begin
            xh <= sat32(66'(hi)); clipped <= 1'b1;
          end else begin
            xh <= x; clipped <= 1'b0;
          end
          state <= S_CLIP;
        end
        S_CLIP: begin
          dreq.start <= 1'b1; dreq.num <= xh; dreq.den <= fac;
          state <= S_DIV1;
        end
        S_DIV1: if (drsp.done) begin
          level <= blend(level_gain, drsp.quo, level);
          state <= S_DIV2; div_wait <= 1'b0;
        end
        S_DIV2: begin
          if (!div_wait) begin
            dreq.start <= 1'b1; dreq.num <= xh; dreq.den <= level;
            div_wait <= 1'b1;
          end else if (drsp.done) begin
            ram_we <= 1'b1;
            ram_wdata <= blend(season_gain, drsp.quo, fac);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          last_sample <= x; last_forecast <= f;
          m_tdata <= f; m_tuser <= clipped; m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result dropped");
  a_clip_obs: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> op_obs) else $error("clip path without observation");
`endif
endmodule
`default_nettype wire

FILE: src/rss_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/rss_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit a cycle: (num << 16) / den, toward zero,
// saturated; zero divisor saturates by dividend sign.
module rss_div (
  input  wire                clk,
  input  wire                rst,
  input  rss_pkg::div_req_t  req,
  output rss_pkg::div_rsp_t  rsp
);
  import rss_pkg::*;
  logic        busy;
  logic [5:0]  cnt;
  logic [47:0] dvd;
  logic [47:0] quo;
  logic [48:0] rem;
  logic [31:0] dmag;
  logic        neg;
  logic [48:0] trial;
  logic [48:0] sh;

  assign sh    = {rem[47:0], dvd[47]};
  assign trial = sh - {17'd0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        if (req.den == 32'sd0) begin
          rsp.done <= 1'b1;
          rsp.quo  <= (req.num > 0) ? 32'sh7fffffff :
                      (req.num < 0) ? 32'sh80000000 : 32'sd0;
        end else begin
          busy <= 1'b1;
          cnt  <= 6'd48;
          dvd  <= {(req.num[31] ? 32'(-req.num) : 32'(req.num)), 16'd0};
          dmag <= req.den[31] ? 32'(-req.den) : 32'(req.den);
          neg  <= req.num[31] ^ req.den[31];
          rem  <= '0;
          quo  <= '0;
        end
      end else if (busy) begin
        if (cnt == 6'd0) begin
          // all 48 quotient bits are in
          busy     <= 1'b0;
          rsp.done <= 1'b1;
          rsp.quo  <= sat32(neg ? -$signed({18'd0, quo}) : $signed({18'd0, quo}));
        end else begin
          dvd <= {dvd[46:0], 1'b0};
          if (!trial[48]) begin
            rem <= trial;
            quo <= {quo[46:0], 1'b1};
          end else begin
            rem <= sh;
            quo <= {quo[46:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/rss_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Bit-pair integer square root of a 64-bit word, one result bit a cycle.
module rss_sqrt (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [63:0] val,
  output logic        done,
  output logic [31:0] root
);
  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] v;
  logic [33:0] rem;
  logic [33:0] trial;
  logic [33:0] sh;

  assign sh    = {rem[31:0], v[63:62]};
  assign trial = sh - {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
        v    <= val;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        v <= {v[61:0], 2'b00};
        if (!trial[33]) begin
          rem  <= trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= sh;
          root <= {root[30:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: verif/tb_robust_seasonal_smoother.sv
`timescale 1ns / 1ps
module tb_robust_seasonal_smoother;
  import rss_pkg::*;

  localparam int SLOTS = 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS = 1500;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  robust_seasonal_smoother #(.SEASON_SLOTS(SLOTS)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic signed [31:0] forecast;
    logic               clipped;
  } smooth_out_t;

  typedef struct {
    logic [1:0]         op;
    logic [2:0]         day;
    logic signed [31:0] value;
    bit                 typed;
    smooth_out_t        want;
  } stim_row_t;

  // predictor state
  logic [15:0]        alpha, gamma, band_k;
  logic signed [31:0] lvl_seed;
  logic [31:0]        var_seed;
  logic signed [31:0] factors [SLOTS];
  logic signed [31:0] lvl;
  logic [63:0]        variance;
  logic signed [31:0] prev_x, prev_f;
  bit                 seeded;

  smooth_out_t forecasts_due[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] q16_div(input logic signed [31:0] n,
                                                 input logic signed [31:0] d);
    longint q;
    if (d == 0) return (n > 0) ? 32'sh7fffffff : (n < 0) ? 32'sh80000000 : 32'sd0;
    q = (longint'(n) * 65536) / longint'(d);
    return clamp32(q);
  endfunction

  function automatic logic signed [31:0] mix(input logic [15:0] g,
                                             input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    longint s;
    s = longint'({1'b0, g}) * a + longint'(65536 - int'(g)) * b + 32768;
    return clamp32(s >>> 16);
  endfunction

  function automatic logic signed [31:0] level_times(input logic signed [31:0] fac);
    longint p;
    p = longint'(lvl) * fac + 32768;
    return clamp32(p >>> 16);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  task automatic reset_predictor();
    alpha = 16'd32768; gamma = 16'd32768; band_k = 16'd8192;
    lvl_seed = 0; var_seed = 32'd65536;
    for (int i = 0; i < SLOTS; i++) factors[i] = 0;
    lvl = 0; variance = 0; prev_x = 0; prev_f = 0; seeded = 1'b0;
  endtask

  // returns 1 when the transaction produces a result
  function automatic bit smooth_step(input logic [1:0] op, input logic [2:0] day,
                                     input logic signed [31:0] x,
                                     output smooth_out_t res);
    longint e, band_v, lo, hi;
    logic [63:0] ue, sq, v, sd;
    logic signed [31:0] f, xh;
    int s;
    s = day % SLOTS;
    res = '0;
    if (op == OP_LOAD) begin
      factors[s] = x;
      return 1'b0;
    end
    if (op != OP_OBSERVE && op != OP_FORECAST) return 1'b0;
    if (op == OP_FORECAST) begin
      res.forecast = level_times(factors[s]);
      return 1'b1;
    end
    if (!seeded) begin
      seeded = 1'b1;
      lvl = lvl_seed;
      variance = {32'd0, var_seed};
      prev_x = x; prev_f = x;
      res.forecast = x;
      return 1'b1;
    end
    e = longint'(prev_x) - longint'(prev_f);
    ue = (e < 0) ? -e : e;
    sq = (ue * ue) >> 16;
    if (sq > 64'hFFFFFFFFFFFF) sq = 64'hFFFFFFFFFFFF;
    v = (64'(C_NEW) * sq + 64'(C_OLD) * variance + 64'd32768) >> 16;
    variance = (v > 64'hFFFFFFFFFFFF) ? 64'hFFFFFFFFFFFF : v;
    f = level_times(factors[s]);
    sd = int_sqrt(variance << 16);
    band_v = longint'((64'(band_k) * sd) >> 12);
    lo = longint'(f) - band_v;
    hi = longint'(f) + band_v;
    xh = x;
    if (longint'(x) < lo) begin
      xh = clamp32(lo);
      res.clipped = 1'b1;
    end else if (longint'(x) > hi) begin
      xh = clamp32(hi);
      res.clipped = 1'b1;
    end
    lvl = mix(alpha, q16_div(xh, factors[s]), lvl);
    factors[s] = mix(gamma, q16_div(xh, lvl), factors[s]);
    prev_x = x;
    prev_f = f;
    res.forecast = f;
    return 1'b1;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LEVEL_GAIN:  alpha = val[15:0];
      REG_SEASON_GAIN: gamma = val[15:0];
      REG_BAND_WIDTH:  band_k = val[15:0];
      REG_LEVEL_INIT:  lvl_seed = val;
      REG_VAR_INIT:    var_seed = val;
      default: ;
    endcase
  endtask

  // send one transaction; the expectation is queued before the handshake edge.
  // tvalid stays up after the handshake so the next call can follow directly.
  task automatic send_item(input logic [1:0] op, input logic [2:0] day,
                           input logic signed [31:0] x, input bit typed,
                           input smooth_out_t want);
    smooth_out_t r;
    bit has;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, x, day, op};
    has = smooth_step(op, day, x, r);
    if (has) begin
      if (typed) r = want;
      forecasts_due.push_back(r);
    end
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (forecasts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // factors reloaded before each run of observations so no slot is read unwritten
  task automatic load_all_factors();
    smooth_out_t none;
    none = '0;
    for (int i = 0; i < SLOTS; i++)
      send_item(OP_LOAD, i[2:0], 32'sd65536 + $signed(32'($urandom_range(0, 40000))) - 20000,
                1'b0, none);
  endtask

  function automatic logic signed [31:0] rand_near(input logic signed [31:0] centre);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return centre + $signed(32'($urandom_range(0, 262143))) - 131072;
    endcase
  endfunction

  // sink side ready, random stalls
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (no_idle) m_tready <= 1'b1;
    else if (!m_tready) m_tready <= (idle_cycles == 0);
    else if ($urandom_range(0, 7) == 0) m_tready <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) idle_cycles <= 0;
    else if (!m_tready && idle_cycles == 0) idle_cycles <= $urandom_range(1, 10);
    else if (idle_cycles > 0) idle_cycles <= idle_cycles - 1;
  end

  // result checker
  always @(posedge clk) begin
    smooth_out_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (forecasts_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h clip %0b", m_tdata, m_tuser);
      end else begin
        exp_r = forecasts_due.pop_front();
        if (m_tdata !== exp_r.forecast || m_tuser !== exp_r.clipped) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %h clip %0b, got %h clip %0b",
                     exp_r.forecast, exp_r.clipped, m_tdata, m_tuser);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  int quiet = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  stim_row_t table_rows [] = '{
    '{OP_LOAD,     3'd0, 32'sd65536,      1'b0, '{32'sd0, 1'b0}},
    '{OP_FORECAST, 3'd0, 32'sd0,          1'b1, '{32'sd0, 1'b0}},
    '{OP_LOAD,     3'd7, 32'sh80000000,   1'b0, '{32'sd0, 1'b0}},
    '{OP_LOAD,     3'd1, 32'sh7fffffff,   1'b0, '{32'sd0, 1'b0}},
    '{OP_LOAD,     3'd2, 32'sd0,          1'b0, '{32'sd0, 1'b0}},
    '{OP_LOAD,     3'd3, 32'sd131072,     1'b0, '{32'sd0, 1'b0}},
    '{OP_LOAD,     3'd4, -32'sd65536,     1'b0, '{32'sd0, 1'b0}},
    '{OP_LOAD,     3'd5, 32'sd32768,      1'b0, '{32'sd0, 1'b0}},
    '{OP_LOAD,     3'd6, 32'sd65536,      1'b0, '{32'sd0, 1'b0}},
    '{2'd3,        3'd5, 32'sh12345678,   1'b0, '{32'sd0, 1'b0}},
    '{OP_OBSERVE,  3'd0, 32'sh7fffffff,   1'b1, '{32'sh7fffffff, 1'b0}},
    '{OP_OBSERVE,  3'd0, 32'sh80000000,   1'b0, '{32'sd0, 1'b0}},
    '{OP_OBSERVE,  3'd2, 32'sd500000,     1'b0, '{32'sd0, 1'b0}},
    '{OP_OBSERVE,  3'd2, -32'sd500000,    1'b0, '{32'sd0, 1'b0}},
    '{OP_OBSERVE,  3'd7, 32'sd100,        1'b0, '{32'sd0, 1'b0}},
    '{OP_OBSERVE,  3'd1, 32'sh7fffffff,   1'b0, '{32'sd0, 1'b0}},
    '{OP_OBSERVE,  3'd4, 32'sd0,          1'b0, '{32'sd0, 1'b0}},
    '{OP_FORECAST, 3'd3, 32'sd0,          1'b0, '{32'sd0, 1'b0}},
    '{OP_FORECAST, 3'd7, 32'sh7fffffff,   1'b0, '{32'sd0, 1'b0}},
    '{OP_OBSERVE,  3'd5, 32'sd70000,      1'b0, '{32'sd0, 1'b0}},
    '{OP_OBSERVE,  3'd6, 32'sd65536,      1'b0, '{32'sd0, 1'b0}}
  };

  typedef struct {
    logic [15:0] a, g, b;
    logic [31:0] li, vi;
  } reg_set_t;

  initial begin
    reg_set_t sets [4];
    smooth_out_t none;
    logic [1:0] op;
    logic signed [31:0] centre;
    int phase_items;
    none = '0;
    reset_predictor();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[i])
      send_item(table_rows[i].op, table_rows[i].day, table_rows[i].value,
                table_rows[i].typed, table_rows[i].want);
    drain();

    sets[0] = '{16'd0, 16'd0, 16'd0, 32'h80000000, 32'd0};
    sets[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7fffffff, 32'hFFFFFFFF};
    sets[2] = '{16'd6553, 16'd3276, 16'd12288, 32'h00010000, 32'h00040000};
    sets[3] = '{16'd49152, 16'd16384, 16'd4096, 32'hFFFF0000, 32'h00001000};

    // the level and variance seeds only act on the first observation, which the
    // table has already made; these phases exercise the gains and band on a
    // running level
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_LEVEL_GAIN, {16'd0, sets[p].a});
      write_reg(REG_SEASON_GAIN, {16'd0, sets[p].g});
      write_reg(REG_BAND_WIDTH, {16'd0, sets[p].b});
      write_reg(REG_LEVEL_INIT, sets[p].li);
      write_reg(REG_VAR_INIT, sets[p].vi);
      load_all_factors();
      centre = 32'sd65536;
      phase_items = RANDOM_ITEMS / 4;
      if (p == 3) no_idle = 1'b0;
      for (int n = 0; n < phase_items; n++) begin
        if (p == 3 && n > phase_items / 2) no_idle = 1'b1;
        case ($urandom_range(0, 19))
          0, 1, 2: op = OP_FORECAST;
          3:       op = OP_LOAD;
          4:       op = 2'd3;
          default: op = OP_OBSERVE;
        endcase
        if (op == OP_LOAD)
          send_item(op, 3'($urandom_range(0, 7)),
                    ($urandom_range(0, 7) == 0) ? $signed($urandom())
                      : 32'sd65536 + $signed(32'($urandom_range(0, 65535))) - 32768,
                    1'b0, none);
        else
          send_item(op, 3'($urandom_range(0, 7)), rand_near(centre), 1'b0, none);
      end
      drain();
    end

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
